FILE: rtl/hsae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsae_pkg
// Constants, register codes and inter-module types for the hall sector
// angle estimator.
// ----------------------------------------------------------------------------
package hsae_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int SECTORS       = 6;
  localparam int STEP_BITS     = 12;
  localparam int STEP_UNITS    = 4096;
  localparam int TURN_UNITS    = 24576;

  localparam int SECTOR_W  = 3;
  localparam int CODE_W    = 3;
  localparam int TABLE_W   = SECTORS * CODE_W;
  localparam int TICK_W    = 16;
  localparam int ACC_W     = 32;
  localparam int VEL_W     = 32;
  localparam int ANGLE_W   = 15;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;

  // correction holds +/- one step with fraction bits, plus sign
  localparam int CORR_W  = FRACTION_BITS + STEP_BITS + 2;
  // dividend is |diff| * step << fraction bits
  localparam int Q_W     = SECTOR_W + STEP_BITS + FRACTION_BITS;
  localparam int QX_W    = (Q_W > VEL_W) ? Q_W : VEL_W;
  localparam int PROD_W  = VEL_W + TICK_W;
  localparam int SUM_W   = ((PROD_W > CORR_W) ? PROD_W : CORR_W) + 1;
  localparam int ASUM_W  = ANGLE_W + 1;
  localparam int DIV_CNT_W = $clog2(Q_W + 1);
  localparam int MUL_CNT_W = $clog2(TICK_W + 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HALL_CODE_TABLE = 2'd0;
  localparam cfg_idx_t REG_SENSOR_INVERTED = 2'd1;
  localparam cfg_idx_t REG_TICK_PERIOD     = 2'd2;

  localparam logic [TABLE_W-1:0] TABLE_RESET = TABLE_W'(183449);
  localparam logic [TICK_W-1:0]  TICK_RESET  = TICK_W'(100);

  localparam logic signed [CORR_W-1:0] STEP_FX = CORR_W'(STEP_UNITS) <<< FRACTION_BITS;
  localparam logic signed [SUM_W-1:0]  SAT_HI  = SUM_W'(STEP_UNITS) <<< FRACTION_BITS;
  localparam logic signed [SUM_W-1:0]  SAT_LO  = -SAT_HI;
  localparam logic [VEL_W-1:0]         VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

  typedef struct packed {
    logic                start;
    logic [SECTOR_W-1:0] mag;
    logic [ACC_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEL_W-1:0] vel;
    logic [TICK_W-1:0]       tick;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  // saturate the quotient to the positive 32-bit range and apply direction
  function automatic logic signed [VEL_W-1:0] vel_from_quot(input logic [Q_W-1:0] q,
                                                            input logic neg);
    logic [QX_W-1:0]  qx;
    logic [VEL_W-1:0] mag;
    qx  = QX_W'(q);
    mag = (qx > QX_W'(VEL_MAX)) ? VEL_MAX : qx[VEL_W-1:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hsae_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsae channel interfaces
// Valid/ready channels for hall samples in and angle results out.
// ----------------------------------------------------------------------------
interface hsae_sample_if;
  import hsae_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [CODE_W-1:0] hall_code;

  modport source (output valid, command, hall_code, input ready);
  modport sink   (input valid, command, hall_code, output ready);
endinterface

interface hsae_angle_if;
  import hsae_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic               status;

  modport source (output valid, angle, status, input ready);
  modport sink   (input valid, angle, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/hall_sector_angle_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hall_sector_angle_estimator
// Decodes hall codes into sectors and interpolates the electrical angle
// between sector edges from a velocity estimate.
// ----------------------------------------------------------------------------
// Flow: an invalid code or zero command goes straight to the output state; a
//   sector change with no velocity update passes the angle state first; a
//   same-sector sample adds a serial multiply, a velocity update a serial divide.
// Throughput: one beat in flight; the next is taken the cycle after the result
//   is registered at the output, which waits while the output is stalled.
// Reset: synchronous; config takes defaults, state clears; result data not reset.
module hall_sector_angle_estimator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire hsae_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [hsae_pkg::CFG_W-1:0]          cfg_data,
  hsae_sample_if.sink                              samples,
  hsae_angle_if.source                             angles
);
  import hsae_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ANG  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // configuration
  logic [TABLE_W-1:0] hall_code_table;
  logic               sensor_inverted;
  logic [TICK_W-1:0]  tick_period;

  // estimator state
  logic [2:0]                state;
  logic [SECTOR_W-1:0]       zero_offset;
  logic [SECTOR_W-1:0]       current_sector;
  logic signed [3:0]         previous_sector_step;
  logic [ACC_W-1:0]          period_accumulator;
  logic signed [VEL_W-1:0]   velocity_estimate;
  logic signed [CORR_W-1:0]  angle_correction;
  logic [ANGLE_W-1:0]        last_angle;
  logic                      vel_neg;

  logic [ANGLE_W-1:0]        res_angle;
  logic                      res_status;
  logic                      out_valid;
  logic [ANGLE_W-1:0]        out_angle;
  logic                      out_status;

  logic                      accept;
  logic                      dec_hit;
  logic [SECTOR_W-1:0]       dec;
  logic [SECTOR_W:0]         rel;
  logic [SECTOR_W-1:0]       sector;
  logic signed [3:0]         diff;
  logic                      same_dir;
  logic [SECTOR_W-1:0]       mag;
  logic                      div_go;
  logic [ACC_W:0]            acc_sum;
  logic signed [SUM_W-1:0]   corr_sum;
  logic signed [CORR_W-1:0]  corr_sat;
  logic signed [ASUM_W-1:0]  base;
  logic signed [ASUM_W-1:0]  asum;
  logic [ANGLE_W-1:0]        angle_now;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      hall_code_table <= TABLE_RESET;
      sensor_inverted <= 1'b0;
      tick_period     <= TICK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HALL_CODE_TABLE: hall_code_table <= cfg_data[TABLE_W-1:0];
        REG_SENSOR_INVERTED: sensor_inverted <= cfg_data[0];
        REG_TICK_PERIOD:     tick_period     <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);

  // lowest matching sector wins
  always_comb begin
    dec_hit = 1'b0;
    dec     = '0;
    for (int s = SECTORS - 1; s >= 0; s--) begin
      if (hall_code_table[CODE_W*s +: CODE_W] == samples.hall_code) begin
        dec_hit = 1'b1;
        dec     = SECTOR_W'(s);
      end
    end
  end

  always_comb begin
    rel      = {1'b0, dec} - {1'b0, zero_offset};
    sector   = rel[SECTOR_W] ? SECTOR_W'(rel + (SECTOR_W+1)'(SECTORS)) : rel[SECTOR_W-1:0];
    diff     = $signed({1'b0, sector}) - $signed({1'b0, current_sector});
    same_dir = (diff > 0 && previous_sector_step > 0) ||
               (diff < 0 && previous_sector_step < 0);
    mag      = diff[3] ? SECTOR_W'(-diff) : SECTOR_W'(diff);
    div_go   = (diff != 0) && (period_accumulator != '0) && (sector != '0) &&
               (current_sector != '0) && same_dir;
    acc_sum  = {1'b0, period_accumulator} + (ACC_W+1)'(tick_period);
  end

  assign div_req.start   = accept && dec_hit && !samples.command && div_go;
  assign div_req.mag     = mag;
  assign div_req.divisor = period_accumulator;

  assign mul_req.start = accept && dec_hit && !samples.command && (diff == 0);
  assign mul_req.vel   = velocity_estimate;
  assign mul_req.tick  = tick_period;

  hsae_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  hsae_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // correction update, clamped to one step either way
  always_comb begin
    corr_sum = $signed({{(SUM_W-CORR_W){angle_correction[CORR_W-1]}}, angle_correction}) +
               $signed({{(SUM_W-PROD_W){mul_rsp.prod[PROD_W-1]}}, mul_rsp.prod});
    if (corr_sum > SAT_HI) begin
      corr_sat = STEP_FX;
    end else if (corr_sum < SAT_LO) begin
      corr_sat = -STEP_FX;
    end else begin
      corr_sat = corr_sum[CORR_W-1:0];
    end
  end

  // sector part is whole units, so floor of the correction can be taken first
  always_comb begin
    base = $signed({1'b0, current_sector, {STEP_BITS{1'b0}}});
    asum = (sensor_inverted ? -base : base) +
           $signed({{(ASUM_W-(CORR_W-FRACTION_BITS)){angle_correction[CORR_W-1]}},
                    angle_correction[CORR_W-1:FRACTION_BITS]});
    if (asum < 0) begin
      asum = asum + ASUM_W'(TURN_UNITS);
    end else if (asum >= $signed(ASUM_W'(TURN_UNITS))) begin
      asum = asum - ASUM_W'(TURN_UNITS);
    end
    angle_now = asum[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      zero_offset          <= '0;
      current_sector       <= '0;
      previous_sector_step <= '0;
      period_accumulator   <= '0;
      velocity_estimate    <= '0;
      angle_correction     <= '0;
      last_angle           <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || angles.ready)) begin
        out_valid <= 1'b1;
      end else if (angles.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!dec_hit) begin
              res_angle  <= last_angle;
              res_status <= 1'b1;
              state      <= S_OUT;
            end else if (samples.command) begin
              zero_offset    <= dec;
              current_sector <= '0;
              last_angle     <= '0;
              res_angle      <= '0;
              res_status     <= 1'b0;
              state          <= S_OUT;
            end else begin
              current_sector <= sector;
              if (diff != 0) begin
                previous_sector_step <= diff;
                state                <= div_go ? S_DIV : S_ANG;
                vel_neg              <= diff[3];
                if (period_accumulator != '0) begin
                  // reversal drops the velocity; sector zero keeps it
                  if (sector != '0 && current_sector != '0 && !same_dir) begin
                    velocity_estimate <= '0;
                  end
                  period_accumulator <= '0;
                  angle_correction   <= '0;
                end
              end else begin
                period_accumulator <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                state              <= S_MUL;
              end
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            velocity_estimate <= vel_from_quot(div_rsp.quot, vel_neg);
            state             <= S_ANG;
          end
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            angle_correction <= corr_sat;
            state            <= S_ANG;
          end
        end
        S_ANG: begin
          last_angle <= angle_now;
          res_angle  <= angle_now;
          res_status <= 1'b0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || angles.ready) begin
            out_angle  <= res_angle;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign angles.valid  = out_valid;
  assign angles.angle  = out_angle;
  assign angles.status = out_status;

  a_corr_bounded: assert property (@(posedge clk) disable iff (rst)
    (angle_correction <= STEP_FX) && (angle_correction >= -STEP_FX))
    else $error("angle correction beyond one step");

  a_last_angle_in_turn: assert property (@(posedge clk) disable iff (rst)
    last_angle < ANGLE_W'(TURN_UNITS))
    else $error("stored angle outside one turn");

  a_sectors_in_range: assert property (@(posedge clk) disable iff (rst)
    (current_sector < SECTOR_W'(SECTORS)) && (zero_offset < SECTOR_W'(SECTORS)))
    else $error("sector or offset out of range");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_MUL))
    else $error("multiplier finished outside its wait state");

endmodule
`default_nettype wire

FILE: rtl/hsae_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsae_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, the sector step
// magnitude times step units << fraction bits, over the accumulated period.
// ----------------------------------------------------------------------------
module hsae_serial_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hsae_pkg::div_req_t req,
  output      hsae_pkg::div_rsp_t rsp
);
  import hsae_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [Q_W-1:0]       dvd;
  logic [ACC_W-1:0]     rem;
  logic [ACC_W-1:0]     divisor;
  logic [ACC_W:0]       trial;
  logic                 fits;

  assign trial = {rem, dvd[Q_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= Q_W'(req.mag) << (STEP_BITS + FRACTION_BITS);
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? ACC_W'(trial - {1'b0, divisor}) : trial[ACC_W-1:0];
      dvd <= {dvd[Q_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < divisor))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: rtl/hsae_serial_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsae_serial_mul
// Shift-add multiplier: velocity times tick period, one multiplier bit
// per cycle.
// ----------------------------------------------------------------------------
module hsae_serial_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hsae_pkg::mul_req_t req,
  output      hsae_pkg::mul_rsp_t rsp
);
  import hsae_pkg::*;

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    mcand;
  logic [TICK_W-1:0]    mplier;
  logic [PROD_W-1:0]    acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(TICK_W);
      end else if (busy) begin
        cnt <= cnt - MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // multiplier is unsigned, so the two's complement sum stays exact
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= {{(PROD_W-VEL_W){req.vel[VEL_W-1]}}, req.vel};
      mplier <= req.tick;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = $signed(acc);

endmodule
`default_nettype wire

FILE: tb/hsae_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsae_tb_pkg
// Sample command and status codes shared by the estimator testbench and its
// checker.
// ----------------------------------------------------------------------------
package hsae_tb_pkg;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_ZERO   = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_CODE = 1'b1;

endpackage

FILE: tb/hsae_angle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsae_angle_checker
// Watches the sample and angle channels and the register port, runs its own
// model of sector decoding and angle interpolation on every accepted sample
// beat, and compares each angle beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module hsae_angle_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  hsae_pkg::cfg_idx_t           cfg_index,
  input  logic [hsae_pkg::CFG_W-1:0]   cfg_data,
  hsae_sample_if                       samples,
  hsae_angle_if                        angles,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);
  import hsae_pkg::*;
  import hsae_tb_pkg::*;

  localparam longint STEP_FIX  = longint'(STEP_UNITS) <<< FRACTION_BITS;
  localparam longint TURN_FIX  = longint'(TURN_UNITS) <<< FRACTION_BITS;
  localparam longint VEL_LIMIT = 64'sh7FFF_FFFF;
  localparam longint ACC_LIMIT = 64'sh0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               status;
  } angle_beat_t;

  angle_beat_t expected_angles[$];

  // register copies
  logic [TABLE_W-1:0] code_table;
  logic               invert;
  logic [TICK_W-1:0]  tick;

  // estimator state
  logic [SECTOR_W-1:0]      offset;
  logic [SECTOR_W-1:0]      sector_now;
  logic [SECTOR_W-1:0]      sector_prev;
  logic signed [3:0]        last_step;
  logic [ACC_W-1:0]         period_sum;
  logic signed [VEL_W-1:0]  velocity;
  logic signed [CORR_W-1:0] correction;
  logic [ANGLE_W-1:0]       held_angle;

  task automatic predict_angle(input logic cmd, input logic [CODE_W-1:0] code,
                               output angle_beat_t res);
    int     found;
    int     sector;
    int     diff;
    int     mag;
    longint q;
    longint acc;
    longint corr;
    longint vel_l;
    longint tick_l;
    longint total;
    found = -1;
    // lowest matching sector wins
    for (int s = SECTORS - 1; s >= 0; s--) begin
      if (code_table[CODE_W*s +: CODE_W] == code) found = s;
    end
    res.status = STATUS_OK;
    if (found < 0) begin
      res.angle  = held_angle;
      res.status = STATUS_BAD_CODE;
    end else if (cmd == CMD_ZERO) begin
      offset     = found[SECTOR_W-1:0];
      sector_now = '0;
      held_angle = '0;
      res.angle  = '0;
    end else begin
      sector = found - int'(offset);
      if (sector < 0) sector += SECTORS;
      sector_prev = sector_now;
      sector_now  = sector[SECTOR_W-1:0];
      diff = int'(sector_now) - int'(sector_prev);
      corr = correction;
      if (diff != 0) begin
        if (period_sum != 0) begin
          if (sector_now != 0 && sector_prev != 0) begin
            if ((diff > 0 && last_step > 0) || (diff < 0 && last_step < 0)) begin
              mag = (diff < 0) ? -diff : diff;
              acc = period_sum;
              q = (longint'(mag) * STEP_FIX) / acc;
              if (q > VEL_LIMIT) q = VEL_LIMIT;
              velocity = VEL_W'((diff < 0) ? -q : q);
            end else begin
              // direction reversed or no previous step
              velocity = '0;
            end
          end
          period_sum = '0;
          corr = 0;
        end
        last_step = diff[3:0];
      end else begin
        acc = period_sum;
        acc += tick;
        if (acc > ACC_LIMIT) acc = ACC_LIMIT;
        period_sum = acc[ACC_W-1:0];
        vel_l  = velocity;
        tick_l = tick;
        corr += vel_l * tick_l;
        if (corr > STEP_FIX) corr = STEP_FIX;
        else if (corr < -STEP_FIX) corr = -STEP_FIX;
      end
      correction = CORR_W'(corr);
      total = sector_now;
      total = total * STEP_FIX;
      if (invert) total = -total;
      total += corr;
      while (total < 0) total += TURN_FIX;
      while (total >= TURN_FIX) total -= TURN_FIX;
      held_angle = total[FRACTION_BITS +: ANGLE_W];
      res.angle  = held_angle;
    end
  endtask

  always @(posedge clk) begin
    angle_beat_t want;
    angle_beat_t got;
    if (rst) begin
      code_table  = TABLE_RESET;
      invert      = 1'b0;
      tick        = TICK_RESET;
      offset      = '0;
      sector_now  = '0;
      sector_prev = '0;
      last_step   = '0;
      period_sum  = '0;
      velocity    = '0;
      correction  = '0;
      held_angle  = '0;
      fail_count  = 0;
      checked     = 0;
      expected_angles.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HALL_CODE_TABLE: code_table = cfg_data[TABLE_W-1:0];
          REG_SENSOR_INVERTED: invert     = cfg_data[0];
          REG_TICK_PERIOD:     tick       = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        predict_angle(samples.command, samples.hall_code, want);
        expected_angles.push_back(want);
      end
      if (angles.valid && angles.ready) begin
        got.angle  = angles.angle;
        got.status = angles.status;
        checked++;
        if (expected_angles.size() == 0) begin
          $error("angle beat with nothing expected: angle %0d status %0d",
                 got.angle, got.status);
          fail_count++;
        end else begin
          want = expected_angles.pop_front();
          if (got.angle !== want.angle) begin
            $error("angle mismatch: expected %0d, got %0d", want.angle, got.angle);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
        end
      end
    end
    pending = expected_angles.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives hall samples into the sector angle estimator: a directed opening
// through invalid codes, zeroing and sector steps in both directions, then
// rotor-like sequences under a range of code tables, inversion and tick
// periods, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import hsae_pkg::*;
  import hsae_tb_pkg::*;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES  = Q_W + 8;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 60;
  localparam int LONG_HOLD     = 400;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  cfg_idx_t           cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  hsae_sample_if samples_ch();
  hsae_angle_if  angles_ch();

  int fail_count;
  int pending;
  int checked;
  int cycles;
  int sent;
  int settings_used;
  bit calm;
  bit hold_request;
  int rotor_sector;
  int rotor_dir;
  logic [TABLE_W-1:0] code_map;

  hall_sector_angle_estimator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_ch),
    .angles    (angles_ch)
  );

  hsae_angle_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samples    (samples_ch),
    .angles     (angles_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    angles_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left   = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        angles_ch.ready = 1'b0;
        stall_left--;
      end else if (calm || $urandom_range(99) < 70) begin
        angles_ch.ready = 1'b1;
      end else begin
        angles_ch.ready = 1'b0;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3);
      end
    end
  end

  // called just after a falling edge; returns just after a falling edge
  task automatic send_sample(input logic cmd, input logic [CODE_W-1:0] code);
    int r;
    int gap;
    samples_ch.command   = cmd;
    samples_ch.hall_code = code;
    samples_ch.valid     = 1'b1;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
    sent++;
    r = $urandom_range(99);
    gap = (calm || r < 60) ? 0 : (r < 92) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    if (gap > 0) begin
      samples_ch.valid     = 1'b0;
      samples_ch.command   = 1'($urandom);
      samples_ch.hall_code = CODE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    samples_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic configure(input logic [TABLE_W-1:0] map, input logic inv,
                           input logic [TICK_W-1:0] tick);
    write_reg(REG_HALL_CODE_TABLE, CFG_W'(map));
    write_reg(REG_SENSOR_INVERTED, CFG_W'(inv));
    write_reg(REG_TICK_PERIOD, CFG_W'(tick));
    code_map = map;
    settings_used++;
  endtask

  initial begin
    logic [3:0]          opening[$];
    logic                cmd;
    logic [CODE_W-1:0]   code;
    logic [CODE_W-1:0]   pool[8];
    logic [CODE_W-1:0]   swap;
    logic [TABLE_W-1:0]  map;
    logic [TICK_W-1:0]   tick;
    logic                inv;
    int                  j;
    int                  r;
    int                  jump;
    int                  move_pct;

    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = REG_HALL_CODE_TABLE;
    cfg_data             = '0;
    samples_ch.valid     = 1'b0;
    samples_ch.command   = CMD_SAMPLE;
    samples_ch.hall_code = '0;
    calm                 = 1'b0;
    hold_request         = 1'b0;
    sent                 = 0;
    settings_used        = 1;
    rotor_sector         = 0;
    rotor_dir            = 1;
    code_map             = TABLE_RESET;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // reset table maps sectors 0..5 to codes 1,3,2,6,4,5
    opening = '{
      {CMD_SAMPLE, 3'd0}, {CMD_ZERO, 3'd7}, {CMD_SAMPLE, 3'd7}, {CMD_ZERO, 3'd1},
      {CMD_SAMPLE, 3'd1}, {CMD_SAMPLE, 3'd3}, {CMD_SAMPLE, 3'd3}, {CMD_SAMPLE, 3'd3},
      {CMD_SAMPLE, 3'd2}, {CMD_SAMPLE, 3'd2}, {CMD_SAMPLE, 3'd2}, {CMD_SAMPLE, 3'd2},
      {CMD_SAMPLE, 3'd2}, {CMD_SAMPLE, 3'd6}, {CMD_SAMPLE, 3'd4}, {CMD_SAMPLE, 3'd4},
      {CMD_SAMPLE, 3'd6}, {CMD_SAMPLE, 3'd6}, {CMD_SAMPLE, 3'd5}, {CMD_SAMPLE, 3'd5},
      {CMD_SAMPLE, 3'd1}, {CMD_SAMPLE, 3'd1}, {CMD_ZERO, 3'd2}, {CMD_SAMPLE, 3'd5},
      {CMD_SAMPLE, 3'd5}
    };
    foreach (opening[k]) send_sample(opening[k][3], opening[k][2:0]);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          map = TABLE_RESET; inv = 1'b0; tick = TICK_W'(1);
        end
        1: begin
          map = TABLE_RESET; inv = 1'b1; tick = '1;
        end
        2: begin
          // every sector shares one code
          map = '0; inv = 1'b0; tick = TICK_RESET;
        end
        3: begin
          // zero tick period: no velocity is ever estimated
          map = '1; inv = 1'b1; tick = '0;
        end
        default: begin
          for (int i = 0; i < 8; i++) pool[i] = CODE_W'(i);
          for (int i = 7; i > 0; i--) begin
            j = $urandom_range(i);
            swap = pool[i]; pool[i] = pool[j]; pool[j] = swap;
          end
          for (int i = 0; i < SECTORS; i++) map[CODE_W*i +: CODE_W] = pool[i];
          if ($urandom_range(4) == 0) map[CODE_W*$urandom_range(5) +: CODE_W] = pool[$urandom_range(5)];
          inv  = 1'($urandom);
          tick = ($urandom_range(3) == 0) ? TICK_W'($urandom_range(65535, 4096))
                                          : TICK_W'($urandom_range(400, 1));
        end
      endcase
      drain_results();
      configure(map, inv, tick);
      calm     = (phase % 4 == 1);
      move_pct = $urandom_range(60, 8);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == 20) hold_request = 1'b1;
        if (phase == 7 && n == 30) drain_results();
        r   = $urandom_range(99);
        cmd = CMD_SAMPLE;
        if (r < 5) begin
          code = CODE_W'($urandom);
        end else begin
          if (r < 8) begin
            cmd = CMD_ZERO;
          end else if ($urandom_range(99) < move_pct) begin
            if ($urandom_range(15) == 0) rotor_dir = -rotor_dir;
            jump = ($urandom_range(11) == 0) ? $urandom_range(3, 2) : 1;
            rotor_sector = (rotor_sector + rotor_dir * jump + SECTORS) % SECTORS;
          end
          code = code_map[CODE_W*rotor_sector +: CODE_W];
        end
        send_sample(cmd, code);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d hall samples, %0d angle beats checked, %0d register settings",
             sent, checked, settings_used);
    $display("summary: included zeroing, invalid codes, reversals and a long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: hall_sector_angle_estimator.f
rtl/hsae_pkg.sv
rtl/hsae_chan_if.sv
rtl/hsae_serial_div.sv
rtl/hsae_serial_mul.sv
rtl/hall_sector_angle_estimator.sv
tb/hsae_tb_pkg.sv
tb/hsae_angle_checker.sv
tb/testbench.sv
